FILE: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication checked outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: hw/rtl/r2fft_pkg.sv
// package with types, constants and the twiddle table of the fft block
package r2fft_pkg;
	localparam int DATA_W = 24;
	localparam int TW_W   = 16;
	localparam int MAX_LOG2 = 6;
	localparam logic signed [DATA_W-1:0] MAX24 = 24'sh7FFFFF;
	localparam logic signed [DATA_W-1:0] MIN24 = -24'sh800000;

	localparam logic CFG_LOG2_POINTS  = 1'b0;
	localparam logic CFG_INVERSE_MODE = 1'b1;

	typedef logic signed [DATA_W-1:0] data_t;

	function automatic logic signed [TW_W-1:0] tw_cos(input logic [4:0] k);
		logic signed [TW_W-1:0] r;
		unique case (k)
			5'd0: r = 16'sd32767;   5'd1: r = 16'sd32610;   5'd2: r = 16'sd32138;
			5'd3: r = 16'sd31357;   5'd4: r = 16'sd30274;   5'd5: r = 16'sd28899;
			5'd6: r = 16'sd27246;   5'd7: r = 16'sd25330;   5'd8: r = 16'sd23170;
			5'd9: r = 16'sd20788;   5'd10: r = 16'sd18205;  5'd11: r = 16'sd15447;
			5'd12: r = 16'sd12540;  5'd13: r = 16'sd9512;   5'd14: r = 16'sd6393;
			5'd15: r = 16'sd3212;   5'd16: r = 16'sd0;      5'd17: r = -16'sd3212;
			5'd18: r = -16'sd6393;  5'd19: r = -16'sd9512;  5'd20: r = -16'sd12540;
			5'd21: r = -16'sd15447; 5'd22: r = -16'sd18205; 5'd23: r = -16'sd20788;
			5'd24: r = -16'sd23170; 5'd25: r = -16'sd25330; 5'd26: r = -16'sd27246;
			5'd27: r = -16'sd28899; 5'd28: r = -16'sd30274; 5'd29: r = -16'sd31357;
			5'd30: r = -16'sd32138; default: r = -16'sd32610;
		endcase
		return r;
	endfunction

	// -sin(k) is cos(k+16) for k < 16, and -cos(k-16) above
	function automatic logic signed [TW_W-1:0] tw_nsin(input logic [4:0] k);
		logic signed [TW_W-1:0] r;
		if (k == 5'd16) r = -16'sd32768;
		else if (k[4]) r = -tw_cos({1'b0, k[3:0]});
		else r = tw_cos({1'b1, k[3:0]});
		return r;
	endfunction

	// clamp a two-bit-wider value to the signed 24-bit range
	function automatic data_t sat24(input logic signed [DATA_W+1:0] v);
		data_t r;
		if (v > $signed({{2{MAX24[DATA_W-1]}}, MAX24})) r = MAX24;
		else if (v < $signed({{2{MIN24[DATA_W-1]}}, MIN24})) r = MIN24;
		else r = v[DATA_W-1:0];
		return r;
	endfunction
endpackage

FILE: hw/rtl/r2fft_bfly.sv
// shared butterfly unit: one complex multiply, rounding, then saturating add and subtract
module r2fft_bfly (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            trivial,
	input  r2fft_pkg::data_t                a_re,
	input  r2fft_pkg::data_t                a_im,
	input  r2fft_pkg::data_t                b_re,
	input  r2fft_pkg::data_t                b_im,
	input  logic signed [r2fft_pkg::TW_W-1:0] w_re,
	input  logic signed [r2fft_pkg::TW_W-1:0] w_im,
	output logic                            done,
	output r2fft_pkg::data_t                x_re,
	output r2fft_pkg::data_t                x_im,
	output r2fft_pkg::data_t                y_re,
	output r2fft_pkg::data_t                y_im
);
	// stage 1: four partial products
	logic signed [39:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1;
	r2fft_pkg::data_t a_re_s1, a_im_s1, b_re_s1, b_im_s1;
	logic triv_s1, vld_s1;
	// stage 2: rounded twiddled value, one bit wider than the data
	logic signed [24:0] t_re_s2, t_im_s2;
	r2fft_pkg::data_t a_re_s2, a_im_s2;
	logic vld_s2;
	logic signed [40:0] sum_re, sum_im;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_rr_s1 <= b_re * w_re;
		p_ii_s1 <= b_im * w_im;
		p_ri_s1 <= b_re * w_im;
		p_ir_s1 <= b_im * w_re;
		a_re_s1 <= a_re; a_im_s1 <= a_im;
		b_re_s1 <= b_re; b_im_s1 <= b_im;
		triv_s1 <= trivial;
	end

	always_comb begin
		sum_re = 41'(p_rr_s1) - 41'(p_ii_s1) + 41'sd16384;
		sum_im = 41'(p_ri_s1) + 41'(p_ir_s1) + 41'sd16384;
	end

	always_ff @(posedge clk) begin
		if (triv_s1) begin
			t_re_s2 <= 25'(b_re_s1);
			t_im_s2 <= 25'(b_im_s1);
		end else begin
			t_re_s2 <= sum_re[39:15];
			t_im_s2 <= sum_im[39:15];
		end
		a_re_s2 <= a_re_s1;
		a_im_s2 <= a_im_s1;
	end

	assign done = vld_s2;
	assign x_re = r2fft_pkg::sat24(26'(a_re_s2) + 26'(t_re_s2));
	assign x_im = r2fft_pkg::sat24(26'(a_im_s2) + 26'(t_im_s2));
	assign y_re = r2fft_pkg::sat24(26'(a_re_s2) - 26'(t_re_s2));
	assign y_im = r2fft_pkg::sat24(26'(a_im_s2) - 26'(t_im_s2));
endmodule

FILE: hw/rtl/radix2_complex_fft.sv
// top level of the frame-based radix-2 decimation-in-time fft
// Collects N = 2^log2_points complex samples (one per request), then runs
// log2 N stages of N/2 butterflies on one shared butterfly unit and emits the
// N bins in order, last_bin marking bin N-1. Each butterfly runs on the work
// memory with one read and one write port (states RDA and RDB read the two
// inputs, WAIT holds while the two-stage multiply path runs and writes the
// first result when it is done, WRY writes the second), and each bin passes
// through the EMRD state, which waits while the previous bin is not taken, and
// the EMIT state; the sample input is not ready during the transform and the
// emit phase. Bit reversal is done on the load address. Inverse mode negates
// the imaginary part on entry and scales by 1/N with a floor shift on emit,
// negating the imaginary part again. A configuration write drops a partial
// frame and takes precedence over a sample offered in the same cycle.
module radix2_complex_fft #(
	parameter int MAX_POINTS   = 64,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_re,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_im,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [23:0]             bin_re,
	output logic signed [23:0]             bin_im,
	output logic                           last_bin,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic                           cfg_index,
	input  logic [2:0]                     cfg_data
);
	localparam int AW = $clog2(MAX_POINTS);
	localparam int CAP = (AW > r2fft_pkg::MAX_LOG2) ? r2fft_pkg::MAX_LOG2 : AW;

	// sequencer states
	localparam logic [2:0] ST_LOAD = 3'd0;
	localparam logic [2:0] ST_RDA  = 3'd1;
	localparam logic [2:0] ST_RDB  = 3'd2;
	localparam logic [2:0] ST_WAIT = 3'd3;
	localparam logic [2:0] ST_WRY  = 3'd4;
	localparam logic [2:0] ST_EMRD = 3'd5;
	localparam logic [2:0] ST_EMIT = 3'd6;

	logic [2:0] state_q;
	logic [2:0] log2_q;
	logic       inv_q;
	logic [AW:0] cnt_q;        // load count, emit index
	logic [2:0] stage_q;       // butterfly stage 1..log2
	logic [AW-1:0] bf_q;       // butterfly index within stage
	logic [2:0] p_eff;

	// work memory, one write and one read port
	r2fft_pkg::data_t mem_re [MAX_POINTS];
	r2fft_pkg::data_t mem_im [MAX_POINTS];
	logic          we;
	logic [AW-1:0] waddr, raddr;
	r2fft_pkg::data_t wd_re, wd_im, rd_re_q, rd_im_q;

	r2fft_pkg::data_t a_re_q, a_im_q;
	r2fft_pkg::data_t y_re_q, y_im_q;
	logic [AW-1:0] ia_q, ib_q;
	logic [4:0]    k_q;
	logic bf_start, busy_q;
	logic bf_done;
	r2fft_pkg::data_t x_re, x_im, y_re, y_im;
	logic out_valid_q, last_q;
	r2fft_pkg::data_t out_re_q, out_im_q;

	// effective length with clamping
	always_comb begin
		p_eff = log2_q;
		if (p_eff == 3'd0) p_eff = 3'd1;
		if (p_eff > 3'(CAP)) p_eff = 3'(CAP);
	end

	// bit reversal of the load index over p_eff bits
	logic [AW-1:0] rev_addr;
	always_comb begin
		rev_addr = '0;
		for (int b = 0; b < AW; b++)
			if (b < int'(p_eff)) rev_addr[int'(p_eff) - 1 - b] = cnt_q[b];
	end

	// butterfly addresses: low (stage-1) bits of bf stay, a zero is inserted
	logic [AW-1:0] half_mask, lo_part, hi_part, ia_c, ib_c;
	logic [4:0] k_c;
	always_comb begin
		half_mask = AW'((1 << (stage_q - 3'd1)) - 1);
		lo_part = bf_q & half_mask;
		hi_part = (bf_q & ~half_mask) << 1;
		ia_c = hi_part | lo_part;
		ib_c = ia_c | (half_mask + AW'(1));
		k_c = 5'((32'(lo_part) << (3'd6 - stage_q)));
	end

	logic last_bf;
	assign last_bf = (32'(bf_q) == ((1 << (p_eff - 3'd1)) - 1));

	logic signed [SAMPLE_WIDTH:0] neg_im;
	assign neg_im = -(SAMPLE_WIDTH+1)'(sample_im);

	// a config request wins over a sample in the same cycle
	assign in_ready  = (state_q == ST_LOAD) && !cfg_valid;
	assign cfg_ready = (state_q == ST_LOAD);
	assign bf_start  = (state_q == ST_WAIT) && !busy_q;

	// memory write selection
	always_comb begin
		we = 1'b0;
		waddr = rev_addr;
		wd_re = r2fft_pkg::data_t'(sample_re);
		wd_im = inv_q ? r2fft_pkg::sat24(26'(neg_im)) : r2fft_pkg::data_t'(sample_im);
		unique case (state_q)
			ST_LOAD: we = in_valid && in_ready;
			ST_WAIT: begin
				we = bf_done;
				waddr = ia_q;
				wd_re = x_re;
				wd_im = x_im;
			end
			ST_WRY: begin
				we = 1'b1;
				waddr = ib_q;
				wd_re = y_re_q;
				wd_im = y_im_q;
			end
			default: we = 1'b0;
		endcase
		unique case (state_q)
			ST_RDA:  raddr = ia_c;
			ST_RDB:  raddr = ib_c;
			default: raddr = cnt_q[AW-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_re[waddr] <= wd_re;
			mem_im[waddr] <= wd_im;
		end
		rd_re_q <= mem_re[raddr];
		rd_im_q <= mem_im[raddr];
	end

	r2fft_bfly u_bfly (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (bf_start),
		.trivial (k_q == 5'd0),
		.a_re    (a_re_q),
		.a_im    (a_im_q),
		.b_re    (rd_re_q),
		.b_im    (rd_im_q),
		.w_re    (r2fft_pkg::tw_cos(k_q)),
		.w_im    (r2fft_pkg::tw_nsin(k_q)),
		.done    (bf_done),
		.x_re    (x_re),
		.x_im    (x_im),
		.y_re    (y_re),
		.y_im    (y_im)
	);

	// inverse scaling on the way out
	r2fft_pkg::data_t sc_re, sc_im;
	always_comb begin
		sc_re = rd_re_q >>> p_eff;
		sc_im = rd_im_q >>> p_eff;
		if (inv_q) sc_im = -sc_im;
		else begin
			sc_re = rd_re_q;
			sc_im = rd_im_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			log2_q <= 3'd6;
			inv_q <= 1'b0;
			cnt_q <= '0;
			stage_q <= 3'd1;
			bf_q <= '0;
			busy_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_LOAD: begin
					if (cfg_valid) begin
						cnt_q <= '0;
						if (cfg_index == r2fft_pkg::CFG_LOG2_POINTS) log2_q <= cfg_data;
						else inv_q <= cfg_data[0];
					end else if (in_valid) begin
						if (32'(cnt_q) == (1 << p_eff) - 1) begin
							cnt_q <= '0;
							stage_q <= 3'd1;
							bf_q <= '0;
							state_q <= ST_RDA;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_RDA: begin
					ia_q <= ia_c;
					ib_q <= ib_c;
					k_q <= k_c;
					state_q <= ST_RDB;
				end
				ST_RDB: begin
					a_re_q <= rd_re_q;
					a_im_q <= rd_im_q;
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (bf_start) busy_q <= 1'b1;
					if (bf_done) begin
						busy_q <= 1'b0;
						y_re_q <= y_re;
						y_im_q <= y_im;
						state_q <= ST_WRY;
					end
				end
				ST_WRY: begin
					state_q <= ST_RDA;
					bf_q <= bf_q + 1'b1;
					if (last_bf) begin
						bf_q <= '0;
						if (stage_q == p_eff) begin
							cnt_q <= '0;
							state_q <= ST_EMRD;
						end else begin
							stage_q <= stage_q + 3'd1;
						end
					end
				end
				ST_EMRD: begin
					if (!out_valid_q || out_ready) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					out_valid_q <= 1'b1;
					out_re_q <= sc_re;
					out_im_q <= sc_im;
					last_q <= (32'(cnt_q) == (1 << p_eff) - 1);
					if (32'(cnt_q) == (1 << p_eff) - 1) begin
						cnt_q <= '0;
						state_q <= ST_LOAD;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						state_q <= ST_EMRD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign bin_re = out_re_q;
	assign bin_im = out_im_q;
	assign last_bin = last_q;
endmodule

FILE: hw/rtl/r2fft_checker.sv
// port-level checker for the fft block and its bind
`include "assert_macros.svh"
module r2fft_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic last_bin,
	input logic cfg_ready
);
	`CHK_IMPL(a_no_load_while_out, clk, arst_n, out_valid && !last_bin, !in_ready, "input ready while a frame is still emitting")
	`CHK_IMPL(a_cfg_with_input, clk, arst_n, in_ready, cfg_ready, "input ready while config is not")
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped before accept")
endmodule

bind radix2_complex_fft r2fft_checker u_r2fft_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.last_bin  (last_bin),
	.cfg_ready (cfg_ready)
);

FILE: dv/radix2_complex_fft_tb.sv
// testbench for the radix-2 fft: directed and random frames checked bin by bin against a local predictor
`timescale 1ns / 1ps
module radix2_complex_fft_tb;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 40;
	localparam int RANDOM_ITEMS   = 360;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [15:0] sample_re;
	logic signed [15:0] sample_im;
	logic               out_valid;
	logic               out_ready;
	logic signed [23:0] bin_re;
	logic signed [23:0] bin_im;
	logic               last_bin;
	logic               cfg_valid;
	logic               cfg_ready;
	logic               cfg_index;
	logic [2:0]         cfg_data;

	radix2_complex_fft u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.sample_re(sample_re), .sample_im(sample_im),
		.out_valid(out_valid), .out_ready(out_ready),
		.bin_re(bin_re), .bin_im(bin_im), .last_bin(last_bin),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	typedef struct packed {
		logic [23:0] re;
		logic [23:0] im;
		logic        last;
	} bin_t;

	// expected bins in emit order
	bin_t bin_queue[$];

	// predictor state: loaded samples, fill level and registers
	longint   frame_re[64];
	longint   frame_im[64];
	int       fill_count;
	bit [2:0] length_reg;
	bit       inverse_reg;

	// twiddle cosines, W_64^k for k = 0..31 in Q1.15
	int cos_rom[32] = '{
		32767, 32610, 32138, 31357, 30274, 28899, 27246, 25330,
		23170, 20788, 18205, 15447, 12540, 9512, 6393, 3212,
		0, -3212, -6393, -9512, -12540, -15447, -18205, -20788,
		-23170, -25330, -27246, -28899, -30274, -31357, -32138, -32610};

	int  error_count;
	int  samples_sent;
	int  bins_seen;
	int  frames_seen;
	int  idle_cycles;
	bit  no_idle;      // when set, neither side inserts gaps or stalls
	bit  run_done;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint clip24(longint v);
		if (v > 8388607) return 8388607;
		if (v < -8388608) return -8388608;
		return v;
	endfunction

	// -sin from the cosine table: a quarter turn away
	function automatic longint nsin_rom(int k);
		if (k == 16) return -32768;
		if (k < 16) return cos_rom[k + 16];
		return -cos_rom[k - 16];
	endfunction

	function automatic int effective_log2();
		if (length_reg == 0) return 1;
		if (length_reg > 6) return 6;
		return length_reg;
	endfunction

	function automatic int reverse_bits(int x, int bits);
		int r;
		r = 0;
		for (int b = 0; b < bits; b++) r = (r << 1) | ((x >> b) & 1);
		return r;
	endfunction

	// bit-reversed load, log2 N butterfly stages, optional 1/N scaling
	function automatic void transform_frame(int p);
		longint re[64];
		longint im[64];
		longint wr, wi, tr, ti;
		int n, half, span, k, r, ip;
		bin_t b;
		n = 1 << p;
		for (int i = 0; i < n; i++) begin
			r = reverse_bits(i, p);
			re[r] = frame_re[i];
			im[r] = inverse_reg ? clip24(-frame_im[i]) : frame_im[i];
		end
		for (int m = 1; m <= p; m++) begin
			half = 1 << (m - 1);
			span = half << 1;
			for (int j = 0; j < half; j++) begin
				k = (j * (64 >> m)) & 31;
				wr = cos_rom[k];
				wi = nsin_rom(k);
				for (int i = j; i + half < n; i += span) begin
					ip = i + half;
					if (k == 0) begin
						// unit twiddle skips the multiplier
						tr = re[ip];
						ti = im[ip];
					end else begin
						tr = (re[ip] * wr - im[ip] * wi + 16384) >>> 15;
						ti = (re[ip] * wi + im[ip] * wr + 16384) >>> 15;
					end
					re[ip] = clip24(re[i] - tr);
					im[ip] = clip24(im[i] - ti);
					re[i]  = clip24(re[i] + tr);
					im[i]  = clip24(im[i] + ti);
				end
			end
		end
		for (int i = 0; i < n; i++) begin
			if (inverse_reg) begin
				re[i] = re[i] >>> p;
				im[i] = -(im[i] >>> p);
			end
			b.re   = re[i][23:0];
			b.im   = im[i][23:0];
			b.last = (i == n - 1);
			bin_queue.push_back(b);
		end
	endfunction

	// one accepted sample; a full frame queues N bins
	function automatic void predict_sample(logic signed [15:0] re, logic signed [15:0] im);
		int p, n;
		p = effective_log2();
		n = 1 << p;
		if (fill_count >= n) fill_count = 0;
		frame_re[fill_count] = re;
		frame_im[fill_count] = im;
		fill_count++;
		if (fill_count == n) begin
			fill_count = 0;
			transform_frame(p);
		end
	endfunction

	function automatic int draw_gap();
		if (no_idle) return 0;
		return $urandom_range(0, 10);
	endfunction

	// send one sample request; valid stays high into the next call when no gap is drawn
	task automatic send_sample(logic signed [15:0] re, logic signed [15:0] im);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		sample_re <= re;
		sample_im <= im;
		do @(posedge clk); while (!in_ready);
		predict_sample(re, im);
		samples_sent++;
	endtask

	task automatic drop_valid();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait until every queued bin has come back, then let the block settle
	task automatic wait_drained();
		while (bin_queue.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write, only issued with the block idle
	task automatic write_reg(logic idx, logic [2:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == r2fft_pkg::CFG_LOG2_POINTS) length_reg = value;
		else inverse_reg = value[0];
		// a write drops any partial frame
		fill_count = 0;
	endtask

	// sample value: half full range, a third extremes, the rest small
	function automatic logic signed [15:0] random_sample();
		case ($urandom_range(0, 5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return $signed(16'($urandom_range(0, 64))) - 16'sd32;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_frame();
		int n;
		n = 1 << effective_log2();
		for (int i = 0; i < n; i++) send_sample(random_sample(), random_sample());
	endtask

	// bins are taken with random stalls on the result side
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// compare each taken bin with the oldest expectation
	always @(posedge clk) begin
		bin_t want;
		if (arst_n && out_valid && out_ready) begin
			bins_seen++;
			if (bin_queue.size() == 0) begin
				$error("bin with no expectation: re %0d im %0d", bin_re, bin_im);
				error_count++;
			end else begin
				want = bin_queue.pop_front();
				if (bin_re !== want.re) begin
					$error("bin_re expected %0d actual %0d", $signed(want.re), bin_re);
					error_count++;
				end
				if (bin_im !== want.im) begin
					$error("bin_im expected %0d actual %0d", $signed(want.im), bin_im);
					error_count++;
				end
				if (last_bin !== want.last) begin
					$error("last_bin expected %0b actual %0b", want.last, last_bin);
					error_count++;
				end
				if (want.last) frames_seen++;
			end
		end
	end

	// watchdog on cycles with no accepted request anywhere
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (!run_done) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout with %0d bins still expected", bin_queue.size());
				$display("tb: failure");
				$finish;
			end
		end
	end

	// reset settings: 64 points forward
	task automatic test_reset_length();
		send_frame();
		drop_valid();
	endtask

	// full-scale corners at short lengths, both directions, length code zero
	task automatic test_extremes();
		write_reg(r2fft_pkg::CFG_LOG2_POINTS, 3'd0);
		write_reg(r2fft_pkg::CFG_INVERSE_MODE, 3'd0);
		send_sample(16'sh7FFF, 16'sh8000);
		send_sample(16'sh8000, 16'sh7FFF);
		drop_valid();
		write_reg(r2fft_pkg::CFG_LOG2_POINTS, 3'd2);
		write_reg(r2fft_pkg::CFG_INVERSE_MODE, 3'd1);
		send_sample(16'sh8000, 16'sh8000);
		send_sample(16'sh8000, 16'sh8000);
		send_sample(16'sh8000, 16'sh8000);
		send_sample(16'sh8000, 16'sh8000);
		send_sample(16'sh7FFF, 16'sh7FFF);
		send_sample(16'sh0000, 16'sh0000);
		send_sample(16'sh0000, 16'sh0000);
		send_sample(16'sh0000, 16'sh0000);
		drop_valid();
		// inverse bit taken from bit zero of the data only
		write_reg(r2fft_pkg::CFG_INVERSE_MODE, 3'd6);
		write_reg(r2fft_pkg::CFG_LOG2_POINTS, 3'd3);
		for (int i = 0; i < 8; i++) send_sample(16'sh7FFF, 16'sh8000);
		drop_valid();
	endtask

	// a write in the middle of a frame throws the loaded samples away
	task automatic test_partial_frame();
		write_reg(r2fft_pkg::CFG_LOG2_POINTS, 3'd2);
		send_sample(16'sh1234, -16'sd77);
		send_sample(16'sh7FFF, 16'sh8000);
		drop_valid();
		write_reg(r2fft_pkg::CFG_INVERSE_MODE, 3'd0);
		send_frame();
		drop_valid();
	endtask

	// random settings and frames, mostly short lengths
	task automatic test_random_frames();
		int frames;
		logic [2:0] len_code;
		while (samples_sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: len_code = 3'd7;
				1: len_code = 3'd6;
				2: len_code = 3'd0;
				default: len_code = 3'($urandom_range(1, 5));
			endcase
			write_reg(r2fft_pkg::CFG_LOG2_POINTS, len_code);
			write_reg(r2fft_pkg::CFG_INVERSE_MODE, 3'($urandom_range(0, 7)));
			no_idle = ($urandom_range(0, 3) == 0);
			frames = (len_code >= 6 || len_code == 0) ? 1 : $urandom_range(1, 3);
			for (int f = 0; f < frames; f++) send_frame();
			// now and then leave a short partial frame for the next write to drop
			if ($urandom_range(0, 4) == 0) send_sample(random_sample(), random_sample());
			drop_valid();
			no_idle = 1'b0;
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		sample_re   = '0;
		sample_im   = '0;
		cfg_valid   = 1'b0;
		cfg_index   = r2fft_pkg::CFG_LOG2_POINTS;
		cfg_data    = '0;
		error_count = 0;
		samples_sent = 0;
		bins_seen   = 0;
		frames_seen = 0;
		idle_cycles = 0;
		no_idle     = 1'b0;
		run_done    = 1'b0;
		fill_count  = 0;
		length_reg  = 3'd6;
		inverse_reg = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_length();
		test_extremes();
		test_partial_frame();
		test_random_frames();

		wait_drained();
		run_done = 1'b1;
		$display("covered %0d samples in %0d frames, %0d bins checked",
			samples_sent, frames_seen, bins_seen);
		$display("lengths 2 to 64 points, forward and inverse, dropped partial frames");
		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("%0d mismatches", error_count);
			$display("tb: failure");
		end
		$finish;
	end
endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/r2fft_pkg.sv
hw/rtl/r2fft_bfly.sv
hw/rtl/radix2_complex_fft.sv
hw/rtl/r2fft_checker.sv
dv/radix2_complex_fft_tb.sv
